@@ src/stq_pkg.sv @@
// Shared types, constants and helpers for the sorted timer queue.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package stq_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 48;
    localparam int MAX_FIRES = 16;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);
    localparam int CMDQ_AW   = 1;
    localparam int CMDQ_DEPTH = 2 ** CMDQ_AW;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_ABS    = 3'd1;
    localparam logic [2:0] REQ_DELAY  = 3'd2;
    localparam logic [2:0] REQ_REPEAT = 3'd3;
    localparam logic [2:0] REQ_CANCEL = 3'd4;

    localparam logic REG_MS_PER_TICK = 1'b0;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    localparam time_t TIME_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_SCHED   = 3'd1,
        ST_REPEAT  = 3'd2,
        ST_CANCEL  = 3'd3,
        ST_EXPIRED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_ABS,
        OP_DELAY,
        OP_REPEAT,
        OP_CANCEL,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t   op;
        slot_t slot;
        time_t when;
        time_t ival;
    } cmd_t;

    typedef struct packed {
        logic       fire_valid;
        logic [3:0] fired_timer;
        logic       fired_repeating;
        logic       cancel_found;
        status_t    slot_status;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_HEAD,
        S_INS,
        S_FIND,
        S_SCHED,
        S_REQ_END,
        S_TICK_END
    } state_t;

    function automatic time_t clamp_ms(input logic [47:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(w);
    endfunction

    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_BITS:0] s;
        s = (TIME_BITS+1)'(a) + (TIME_BITS+1)'(b);
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

endpackage

@@ src/stq_front.sv @@
// Front end: accepts request beats and decodes them into queue commands.
// Depends on stq_pkg.
`timescale 1ns / 1ps
module stq_front
    import stq_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  req_type,
    input  logic [3:0]  timer_id,
    input  logic [47:0] when_ms,
    input  logic [47:0] interval_ms,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    op_t op;

    always_comb
    begin
        unique case (req_type)
            REQ_TICK:   op = OP_TICK;
            REQ_ABS:    op = OP_ABS;
            REQ_DELAY:  op = OP_DELAY;
            REQ_REPEAT: op = OP_REPEAT;
            REQ_CANCEL: op = OP_CANCEL;
            default:    op = OP_NOP;
        endcase
        // turn requests to slots that do not exist into no-ops
        if (op != OP_TICK && 32'(timer_id) >= 32'(SLOTS))
        begin
            op = OP_NOP;
        end
    end

    assign s_tready   = !q_full;
    assign q_push     = s_tvalid && !q_full;
    assign q_cmd.op   = op;
    assign q_cmd.slot = SLOT_W'(timer_id);
    assign q_cmd.when = clamp_ms(when_ms);
    assign q_cmd.ival = clamp_ms(interval_ms);

endmodule

@@ src/stq_cmd_fifo.sv @@
// Short command queue between front end and back end.
// Depends on stq_pkg.
`timescale 1ns / 1ps
module stq_cmd_fifo
    import stq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic valid,
    input  logic pop,
    output cmd_t pop_cmd
);

    cmd_t                   mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]     wr_reg, wr_next;
    logic [CMDQ_AW-1:0]     rd_reg, rd_next;
    logic [CMDQ_AW:0]       cnt_reg, cnt_next;

    assign full    = (cnt_reg == (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

@@ src/stq_back.sv @@
// Back end: sequencer that owns the timer slots and the sorted queue,
// walks the queue one entry a cycle and drives the result register.
// Depends on stq_pkg.
`timescale 1ns / 1ps
module stq_back
    import stq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [9:0] ms_per_tick,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;
    cmd_t           cmd_reg, cmd_next;
    time_t          now_reg, now_next;
    time_t          ft_reg [SLOTS];
    time_t          ft_next [SLOTS];
    time_t          iv_reg [SLOTS];
    time_t          iv_next [SLOTS];
    status_t        st_reg [SLOTS];
    status_t        st_next [SLOTS];
    slot_t          ord_reg [SLOTS];
    slot_t          ord_next [SLOTS];
    cnt_t           cnt_reg, cnt_next;
    cnt_t           pos_reg, pos_next;
    logic [FIRE_W-1:0] nfire_reg, nfire_next;
    slot_t          slot_reg, slot_next;
    logic           found_reg, found_next;
    logic           pend_valid_reg, pend_valid_next;
    result_t        pend_reg, pend_next;
    logic           out_valid_reg, out_valid_next;
    result_t        out_reg, out_next;

    slot_t  head_slot;
    logic   head_due;
    logic   head_rep;
    slot_t  walk_idx;
    logic   walk_more;
    logic   find_hit;
    logic   find_end;
    logic   out_free;

    assign head_slot = ord_reg[0];
    assign head_rep  = (iv_reg[head_slot] != '0);
    assign head_due  = (cnt_reg != '0) && (nfire_reg != FIRE_W'(MAX_FIRES))
                       && (ft_reg[head_slot] <= now_reg);
    assign walk_idx  = pos_reg[SLOT_W-1:0];
    assign walk_more = (pos_reg < cnt_reg)
                       && (ft_reg[ord_reg[walk_idx]] <= ft_reg[slot_reg]);
    assign find_end  = (pos_reg >= cnt_reg);
    assign find_hit  = !find_end && (ord_reg[walk_idx] == slot_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_TICK)
                        state_next = S_TICK;
                    else if (cmd.op == OP_NOP)
                        state_next = S_TICK_END;
                    else
                        state_next = S_FIND;
                end
            end
            S_TICK:
                state_next = S_HEAD;
            S_HEAD:
            begin
                if (!head_due)
                    state_next = S_TICK_END;
                else if (pend_valid_reg && !out_free)
                    state_next = S_HEAD;
                else if (head_rep)
                    state_next = S_INS;
            end
            S_INS:
            begin
                if (!walk_more)
                    state_next = ret_reg;
            end
            S_FIND:
            begin
                if (find_hit || find_end)
                    state_next = S_SCHED;
            end
            S_SCHED:
                state_next = (cmd_reg.op == OP_CANCEL) ? S_REQ_END : S_INS;
            S_REQ_END, S_TICK_END:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ret_next        = ret_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        ft_next         = ft_reg;
        iv_next         = iv_reg;
        st_next         = st_reg;
        ord_next        = ord_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        nfire_next      = nfire_reg;
        slot_next       = slot_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        cmd_pop         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    cmd_next        = cmd;
                    slot_next       = cmd.slot;
                    pos_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            S_TICK:
            begin
                now_next   = sat_add(now_reg, TIME_BITS'(ms_per_tick));
                nfire_next = '0;
            end
            S_HEAD:
            begin
                if (head_due && (!pend_valid_reg || out_free))
                begin
                    // previous fire is not the final beat: release it
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_next.last  = 1'b0;
                    end
                    for (int j = 0; j < SLOTS - 1; j++)
                    begin
                        ord_next[j] = ord_reg[j+1];
                    end
                    cnt_next   = cnt_reg - 1'b1;
                    nfire_next = nfire_reg + 1'b1;
                    pend_valid_next           = 1'b1;
                    pend_next.fire_valid      = 1'b1;
                    pend_next.fired_timer     = 4'(head_slot);
                    pend_next.fired_repeating = head_rep;
                    pend_next.cancel_found    = 1'b0;
                    pend_next.slot_status     = head_rep ? st_reg[head_slot] : ST_EXPIRED;
                    pend_next.last            = 1'b0;
                    if (head_rep)
                    begin
                        ft_next[head_slot] = sat_add(now_reg, iv_reg[head_slot]);
                        slot_next          = head_slot;
                        pos_next           = '0;
                        ret_next           = S_HEAD;
                    end
                    else
                    begin
                        st_next[head_slot] = ST_EXPIRED;
                    end
                end
            end
            S_INS:
            begin
                if (walk_more)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else if (cnt_reg < CNT_W'(SLOTS))
                begin
                    // open a gap at pos and drop the slot in
                    for (int j = 1; j < SLOTS; j++)
                    begin
                        if (CNT_W'(j) > pos_reg)
                            ord_next[j] = ord_reg[j-1];
                    end
                    for (int j = 0; j < SLOTS; j++)
                    begin
                        if (CNT_W'(j) == pos_reg)
                            ord_next[j] = slot_reg;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIND:
            begin
                if (find_hit)
                begin
                    for (int j = 0; j < SLOTS - 1; j++)
                    begin
                        if (CNT_W'(j) >= pos_reg)
                            ord_next[j] = ord_reg[j+1];
                    end
                    cnt_next          = cnt_reg - 1'b1;
                    found_next        = 1'b1;
                    st_next[slot_reg] = ST_CANCEL;
                end
                else if (!find_end)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_SCHED:
            begin
                if (cmd_reg.op != OP_CANCEL)
                begin
                    ft_next[slot_reg] = (cmd_reg.op == OP_ABS) ? cmd_reg.when
                                        : sat_add(now_reg, cmd_reg.when);
                    iv_next[slot_reg] = (cmd_reg.op == OP_REPEAT) ? cmd_reg.ival : '0;
                    st_next[slot_reg] = (cmd_reg.op == OP_REPEAT) ? ST_REPEAT : ST_SCHED;
                    pos_next          = '0;
                    ret_next          = S_REQ_END;
                end
            end
            S_REQ_END:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.fire_valid      = 1'b0;
                    out_next.fired_timer     = '0;
                    out_next.fired_repeating = 1'b0;
                    out_next.cancel_found    = found_reg;
                    out_next.slot_status     = st_reg[slot_reg];
                    out_next.last            = 1'b1;
                end
            end
            S_TICK_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next.fire_valid      = 1'b0;
                        out_next.fired_timer     = '0;
                        out_next.fired_repeating = 1'b0;
                        out_next.cancel_found    = 1'b0;
                        out_next.slot_status     = ST_IDLE;
                    end
                    out_next.last   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            now_reg        <= '0;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            nfire_reg      <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int j = 0; j < SLOTS; j++)
            begin
                st_reg[j] <= ST_IDLE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            now_reg        <= now_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            nfire_reg      <= nfire_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            st_reg         <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        ft_reg   <= ft_next;
        iv_reg   <= iv_next;
        ord_reg  <= ord_next;
        slot_reg <= slot_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

@@ src/sorted_timer_queue_unit.sv @@
// Sorted timer queue: a schedule or cancel request does a find walk, one queue
// entry a cycle, and a schedule then an insert walk at the same rate; a tick
// advances the clock and fires due timers one by one, holding while the output
// is busy, with an insert walk for each repeating one. One request is carried out at a time; a two-entry
// command queue lets up to two more beats be taken meanwhile.
// Reset is asynchronous: clock, queue and slot status clear at once, no sweep.
`timescale 1ns / 1ps
module sorted_timer_queue_unit
    import stq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] timer_id, [51:4] when_ms, [99:52] interval_ms, rest zero
    input  logic [103:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [3:0] fired_timer, [4] fired_repeating, [5] cancel_found, [8:6] slot_status
    output logic [15:0]  m_tdata,
    // [0] fire_valid
    output logic         m_tuser,
    output logic         m_tlast
);

    logic [9:0] ms_per_tick_reg;
    logic       q_full;
    logic       q_push;
    cmd_t       q_cmd;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_out;
    result_t    res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MS_PER_TICK) ? {22'd0, ms_per_tick_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_per_tick_reg <= 10'd1;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_MS_PER_TICK)
        begin
            ms_per_tick_reg <= pwdata[9:0];
        end
    end

    stq_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .req_type    (s_tuser),
        .timer_id    (s_tdata[3:0]),
        .when_ms     (s_tdata[51:4]),
        .interval_ms (s_tdata[99:52]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    stq_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_cmd  (q_out)
    );

    stq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ms_per_tick (ms_per_tick_reg),
        .cmd_valid   (q_valid),
        .cmd         (q_out),
        .cmd_pop     (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res)
    );

    assign m_tdata = {7'd0, res.slot_status, res.cancel_found, res.fired_repeating,
                      res.fired_timer};
    assign m_tuser = res.fire_valid;
    assign m_tlast = res.last;

endmodule
